### src/ksrs_pkg.sv
// ============================================================================
// ksrs_pkg: shared types and constants of the k-sparse recovery sketch
// Item structs, memory entry layout, opcode and status codes, control structs.
// ============================================================================
package ksrs_pkg;

    localparam int ROWS_DEF     = 5;
    localparam int SPARSITY_DEF = 101;

    // Fingerprint modulus, 2^30 > PRIME
    localparam int          PRIME_W = 30;
    localparam logic [29:0] PRIME   = 30'd1000000007;

    // Number of stored row masks; row r uses mask r mod MASKS
    localparam int MASKS = 5;

    // Configuration register indexes
    localparam int          CFG_IDX_W = 3;
    localparam logic [2:0]  CFG_ROW_LAST = 3'd4;
    localparam logic [2:0]  CFG_FPX   = 3'd5;
    localparam logic [2:0]  CFG_FPY   = 3'd6;

    // Request codes
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_PROBE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_ONE   = 2'd1;
    localparam logic [1:0] ST_COLL  = 2'd2;

    // Multiplier operand selects
    localparam logic [1:0] MUL_KEY = 2'd0;
    localparam logic [1:0] MUL_WH  = 2'd1;
    localparam logic [1:0] MUL_WC  = 2'd2;
    localparam logic [1:0] MUL_CH  = 2'd3;

    // Divider operand selects
    localparam logic [2:0] DIV_H   = 3'd0;
    localparam logic [2:0] DIV_MUL = 3'd1;
    localparam logic [2:0] DIV_ROW = 3'd2;
    localparam logic [2:0] DIV_SUM = 3'd3;
    localparam logic [2:0] DIV_HQ  = 3'd4;

    typedef struct packed {
        logic               req_type;
        logic [29:0]        x;
        logic [29:0]        y;
        logic signed [15:0] weight;
        logic [2:0]         row;
        logic [7:0]         bucket;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] count;
    } out_item_t;

    typedef struct packed {
        logic [31:0] count;
        logic [63:0] x_sum;
        logic [63:0] y_sum;
        logic [29:0] x_fp;
        logic [29:0] y_fp;
    } entry_t;

    typedef struct packed {
        logic       load_in;
        logic       mul_go;
        logic [1:0] mul_sel;
        logic       key_ld;
        logic       div_go;
        logic [2:0] div_sel;
        logic       h_ld;
        logic       f_ld;
        logic       d_ld;
        logic       axis_clr;
        logic       axis_set;
        logic       row_init;
        logic       row_adv;
        logic       rd_row;
        logic       rd_probe;
        logic       mem_wr;
        logic       clr_step;
        logic       q_ld;
        logic       pt_ld;
        logic       out_ld;
        logic [1:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic is_probe;
        logic oob;
        logic cnt_zero;
        logic div_busy;
        logic div_done;
        logic rem_nz;
        logic fp_match;
        logic axis;
        logic row_last;
        logic clr_last;
        logic out_busy;
    } sts_t;

endpackage

### src/ksrs_div.sv
// ============================================================================
// ksrs_div: shared shift-subtract divider
// 64-bit dividend by 32-bit divisor, four quotient bits per cycle.
// ============================================================================
module ksrs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quot,
    output logic [31:0] rem
);

    localparam int DIG   = 4;
    localparam int STEPS = 64 / DIG;
    localparam int CW    = $clog2(STEPS);

    logic [63:0]   num_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [63:0]   num_next;
    logic [31:0]   rem_next;

    always_comb
    begin
        logic [32:0] t;
        logic [31:0] r;
        logic [63:0] n;
        r = rem_reg;
        n = num_reg;
        for (int i = 0; i < DIG; i++)
        begin
            t = {r, n[63]};
            n = {n[62:0], 1'b0};
            if (t >= {1'b0, den_reg})
            begin
                t    = t - {1'b0, den_reg};
                n[0] = 1'b1;
            end
            r = t[31:0];
        end
        num_next = n;
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

### src/ksrs_dp.sv
// ============================================================================
// ksrs_dp: sketch datapath
// Config masks, hashing, shared multiplier and divider, bucket memory, result.
// ============================================================================
module ksrs_dp #(
    parameter int ROWS     = ksrs_pkg::ROWS_DEF,
    parameter int SPARSITY = ksrs_pkg::SPARSITY_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ksrs_pkg::in_item_t    in_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  ksrs_pkg::cmd_t        cmd,
    output ksrs_pkg::sts_t        sts,
    input  logic                  out_ready,
    output logic                  out_valid,
    output ksrs_pkg::out_item_t   out_data
);

    localparam int NB   = 2 * SPARSITY;
    localparam int NENT = ROWS * NB;
    localparam int AW   = $clog2(NENT);
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    function automatic logic [63:0] mix(input logic [63:0] v, input logic [63:0] m);
        logic [63:0] t;
        t = v ^ m;
        t = t ^ (t << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // configuration
    logic [63:0] row_mask_reg [ksrs_pkg::MASKS];
    logic [63:0] fpx_reg;
    logic [63:0] fpy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ksrs_pkg::MASKS; i++)
            begin
                row_mask_reg[i] <= '0;
            end
            fpx_reg <= '0;
            fpy_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index <= ksrs_pkg::CFG_ROW_LAST)
            begin
                row_mask_reg[cfg_index] <= cfg_data;
            end
            else if (cfg_index == ksrs_pkg::CFG_FPX)
            begin
                fpx_reg <= cfg_data;
            end
            else if (cfg_index == ksrs_pkg::CFG_FPY)
            begin
                fpy_reg <= cfg_data;
            end
        end
    end

    // working registers
    ksrs_pkg::in_item_t in_reg;
    ksrs_pkg::entry_t   rd_reg;
    ksrs_pkg::entry_t   mem [NENT];
    ksrs_pkg::entry_t   upd;
    logic [63:0]        key_reg;
    logic [63:0]        mul_reg;
    logic [29:0]        h_reg;
    logic [29:0]        fx_reg;
    logic [29:0]        fy_reg;
    logic [63:0]        dx_reg;
    logic [63:0]        dy_reg;
    logic [31:0]        qs_reg;
    logic [31:0]        px_reg;
    logic [31:0]        py_reg;
    logic               axis_reg;
    logic [RW-1:0]      row_reg;
    logic [2:0]         msk_reg;
    logic [AW-1:0]      base_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      clr_reg;
    logic               out_valid_reg;
    ksrs_pkg::out_item_t out_reg;

    // derived values
    logic               wneg;
    logic [15:0]        wmag;
    logic               cneg;
    logic [31:0]        cmag;
    logic [29:0]        coord;
    logic [63:0]        fmask;
    logic [63:0]        sum_ax;
    logic               sneg;
    logic [63:0]        smag;
    logic [29:0]        fp_ax;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        div_n;
    logic [31:0]        div_d;
    logic               div_busy;
    logic               div_done;
    logic [63:0]        div_q;
    logic [31:0]        div_r;
    logic [29:0]        rem30;
    logic               fneg;
    logic [29:0]        fix;
    logic [63:0]        qsig;
    logic [AW-1:0]      probe_addr;
    logic [AW-1:0]      row_addr;
    logic [30:0]        sx;
    logic [30:0]        sy;

    assign wneg   = in_reg.weight[15];
    assign wmag   = wneg ? 16'(-in_reg.weight) : in_reg.weight;
    assign cneg   = rd_reg.count[31];
    assign cmag   = cneg ? (32'd0 - rd_reg.count) : rd_reg.count;
    assign coord  = axis_reg ? in_reg.y : in_reg.x;
    assign fmask  = axis_reg ? fpy_reg : fpx_reg;
    assign sum_ax = axis_reg ? rd_reg.y_sum : rd_reg.x_sum;
    assign fp_ax  = axis_reg ? rd_reg.y_fp : rd_reg.x_fp;
    assign sneg   = sum_ax[63];
    assign smag   = sneg ? (64'd0 - sum_ax) : sum_ax;

    always_comb
    begin
        case (cmd.mul_sel)
            ksrs_pkg::MUL_KEY:
            begin
                mul_a = 32'(in_reg.x);
                mul_b = 32'(ksrs_pkg::PRIME);
            end
            ksrs_pkg::MUL_WH:
            begin
                mul_a = 32'(wmag);
                mul_b = 32'(h_reg);
            end
            ksrs_pkg::MUL_WC:
            begin
                mul_a = 32'(wmag);
                mul_b = 32'(coord);
            end
            default:
            begin
                mul_a = cmag;
                mul_b = 32'(h_reg);
            end
        endcase
    end

    assign qsig = {{32{qs_reg[31]}}, qs_reg};

    always_comb
    begin
        case (cmd.div_sel)
            ksrs_pkg::DIV_H:
            begin
                div_n = mix(64'(coord), fmask);
                div_d = 32'(ksrs_pkg::PRIME);
            end
            ksrs_pkg::DIV_MUL:
            begin
                div_n = mul_reg;
                div_d = 32'(ksrs_pkg::PRIME);
            end
            ksrs_pkg::DIV_ROW:
            begin
                div_n = mix(key_reg, row_mask_reg[msk_reg]);
                div_d = 32'(NB);
            end
            ksrs_pkg::DIV_SUM:
            begin
                div_n = smag;
                div_d = cmag;
            end
            default:
            begin
                div_n = mix(qsig, fmask);
                div_d = 32'(ksrs_pkg::PRIME);
            end
        endcase
    end

    ksrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // fold the sign of the multiplier back into the residue
    assign rem30 = div_r[29:0];
    assign fneg  = (in_reg.req_type == ksrs_pkg::REQ_PROBE) ? cneg : wneg;
    assign fix   = (fneg && rem30 != '0) ? (ksrs_pkg::PRIME - rem30) : rem30;

    assign probe_addr = AW'(in_reg.row) * AW'(NB) + AW'(in_reg.bucket);
    assign row_addr   = base_reg + div_r[AW-1:0];

    always_comb
    begin
        upd       = rd_reg;
        upd.count = rd_reg.count + 32'(in_reg.weight);
        upd.x_sum = rd_reg.x_sum + dx_reg;
        upd.y_sum = rd_reg.y_sum + dy_reg;
        sx = {1'b0, rd_reg.x_fp} + {1'b0, fx_reg};
        sy = {1'b0, rd_reg.y_fp} + {1'b0, fy_reg};
        if (sx >= {1'b0, ksrs_pkg::PRIME})
        begin
            sx = sx - {1'b0, ksrs_pkg::PRIME};
        end
        if (sy >= {1'b0, ksrs_pkg::PRIME})
        begin
            sy = sy - {1'b0, ksrs_pkg::PRIME};
        end
        upd.x_fp = sx[29:0];
        upd.y_fp = sy[29:0];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.mul_go)
        begin
            mul_reg <= mul_a * mul_b;
        end
        if (cmd.key_ld)
        begin
            key_reg <= mul_reg + 64'(in_reg.y);
        end
        if (cmd.h_ld)
        begin
            h_reg <= rem30;
        end
        if (cmd.f_ld)
        begin
            if (axis_reg)
            begin
                fy_reg <= fix;
            end
            else
            begin
                fx_reg <= fix;
            end
        end
        if (cmd.d_ld)
        begin
            if (axis_reg)
            begin
                dy_reg <= wneg ? (64'd0 - mul_reg) : mul_reg;
            end
            else
            begin
                dx_reg <= wneg ? (64'd0 - mul_reg) : mul_reg;
            end
        end
        if (cmd.q_ld)
        begin
            qs_reg <= (sneg != cneg) ? 32'(64'd0 - div_q) : div_q[31:0];
        end
        if (cmd.pt_ld)
        begin
            if (axis_reg)
            begin
                py_reg <= qs_reg;
            end
            else
            begin
                px_reg <= qs_reg;
            end
        end
        if (cmd.rd_row)
        begin
            addr_reg <= row_addr;
        end
    end

    // bucket memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[clr_reg] <= '0;
        end
        else if (cmd.mem_wr)
        begin
            mem[addr_reg] <= upd;
        end
        if (cmd.rd_row)
        begin
            rd_reg <= mem[row_addr];
        end
        else if (cmd.rd_probe)
        begin
            rd_reg <= mem[probe_addr];
        end
    end

    // control-side counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= 1'b0;
            row_reg  <= '0;
            msk_reg  <= '0;
            base_reg <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            if (cmd.axis_clr)
            begin
                axis_reg <= 1'b0;
            end
            else if (cmd.axis_set)
            begin
                axis_reg <= 1'b1;
            end
            if (cmd.row_init)
            begin
                row_reg  <= '0;
                msk_reg  <= '0;
                base_reg <= '0;
            end
            else if (cmd.row_adv)
            begin
                row_reg  <= row_reg + 1'b1;
                msk_reg  <= (msk_reg == 3'(ksrs_pkg::MASKS - 1)) ? 3'd0 : msk_reg + 3'd1;
                base_reg <= base_reg + AW'(NB);
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_reg.status <= cmd.out_status;
            if (cmd.out_status == ksrs_pkg::ST_ONE)
            begin
                out_reg.point_x <= px_reg;
                out_reg.point_y <= py_reg;
                out_reg.count   <= rd_reg.count;
            end
            else
            begin
                out_reg.point_x <= '0;
                out_reg.point_y <= '0;
                out_reg.count   <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign sts.is_probe = (in_reg.req_type == ksrs_pkg::REQ_PROBE);
    assign sts.oob      = ({1'b0, in_reg.row} >= 4'(ROWS)) || (12'(in_reg.bucket) >= 12'(NB));
    assign sts.cnt_zero = (rd_reg.count == '0);
    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.rem_nz   = (div_r != '0);
    assign sts.fp_match = (fix == fp_ax);
    assign sts.axis     = axis_reg;
    assign sts.row_last = (row_reg == RW'(ROWS - 1));
    assign sts.clr_last = (clr_reg == AW'(NENT - 1));
    assign sts.out_busy = out_valid_reg;

endmodule

### src/ksrs_ctrl.sv
// ============================================================================
// ksrs_ctrl: sketch sequencer
// Steps the datapath through clearing, update and probe sequences.
// ============================================================================
module ksrs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_ready,
    input  ksrs_pkg::sts_t  sts,
    output ksrs_pkg::cmd_t  cmd
);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_DISP = 5'd2;
    localparam logic [4:0] U_KY   = 5'd3;
    localparam logic [4:0] U_HS   = 5'd4;
    localparam logic [4:0] U_HW   = 5'd5;
    localparam logic [4:0] U_WM   = 5'd6;
    localparam logic [4:0] U_WR   = 5'd7;
    localparam logic [4:0] U_FW   = 5'd8;
    localparam logic [4:0] U_DL   = 5'd9;
    localparam logic [4:0] U_RS   = 5'd10;
    localparam logic [4:0] U_RW   = 5'd11;
    localparam logic [4:0] U_RD   = 5'd12;
    localparam logic [4:0] P_RD   = 5'd13;
    localparam logic [4:0] P_DS   = 5'd14;
    localparam logic [4:0] P_DW   = 5'd15;
    localparam logic [4:0] P_HS   = 5'd16;
    localparam logic [4:0] P_HW   = 5'd17;
    localparam logic [4:0] P_CM   = 5'd18;
    localparam logic [4:0] P_CR   = 5'd19;
    localparam logic [4:0] P_CW   = 5'd20;
    localparam logic [4:0] P_OUT  = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] code_reg;
    logic [1:0] code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            code_reg  <= ksrs_pkg::ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.is_probe)
                begin
                    if (sts.oob)
                    begin
                        code_next  = ksrs_pkg::ST_EMPTY;
                        state_next = P_OUT;
                    end
                    else
                    begin
                        cmd.rd_probe = 1'b1;
                        state_next   = P_RD;
                    end
                end
                else
                begin
                    cmd.mul_go  = 1'b1;
                    cmd.mul_sel = ksrs_pkg::MUL_KEY;
                    state_next  = U_KY;
                end
            end
            U_KY:
            begin
                cmd.key_ld   = 1'b1;
                cmd.axis_clr = 1'b1;
                state_next   = U_HS;
            end
            U_HS:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = ksrs_pkg::DIV_H;
                state_next  = U_HW;
            end
            U_HW:
            begin
                if (sts.div_done)
                begin
                    cmd.h_ld   = 1'b1;
                    state_next = U_WM;
                end
            end
            U_WM:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = ksrs_pkg::MUL_WH;
                state_next  = U_WR;
            end
            U_WR:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = ksrs_pkg::DIV_MUL;
                state_next  = U_FW;
            end
            U_FW:
            begin
                if (sts.div_done)
                begin
                    cmd.f_ld    = 1'b1;
                    cmd.mul_go  = 1'b1;
                    cmd.mul_sel = ksrs_pkg::MUL_WC;
                    state_next  = U_DL;
                end
            end
            U_DL:
            begin
                cmd.d_ld = 1'b1;
                if (sts.axis)
                begin
                    cmd.row_init = 1'b1;
                    state_next   = U_RS;
                end
                else
                begin
                    cmd.axis_set = 1'b1;
                    state_next   = U_HS;
                end
            end
            U_RS:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = ksrs_pkg::DIV_ROW;
                state_next  = U_RW;
            end
            U_RW:
            begin
                if (sts.div_done)
                begin
                    cmd.rd_row = 1'b1;
                    state_next = U_RD;
                end
            end
            U_RD:
            begin
                cmd.mem_wr = 1'b1;
                if (sts.row_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.row_adv = 1'b1;
                    state_next  = U_RS;
                end
            end
            P_RD:
            begin
                cmd.axis_clr = 1'b1;
                if (sts.cnt_zero)
                begin
                    code_next  = ksrs_pkg::ST_EMPTY;
                    state_next = P_OUT;
                end
                else
                begin
                    state_next = P_DS;
                end
            end
            P_DS:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = ksrs_pkg::DIV_SUM;
                state_next  = P_DW;
            end
            P_DW:
            begin
                if (sts.div_done)
                begin
                    if (sts.rem_nz)
                    begin
                        code_next  = ksrs_pkg::ST_COLL;
                        state_next = P_OUT;
                    end
                    else
                    begin
                        cmd.q_ld   = 1'b1;
                        state_next = P_HS;
                    end
                end
            end
            P_HS:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = ksrs_pkg::DIV_HQ;
                state_next  = P_HW;
            end
            P_HW:
            begin
                if (sts.div_done)
                begin
                    cmd.h_ld   = 1'b1;
                    state_next = P_CM;
                end
            end
            P_CM:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = ksrs_pkg::MUL_CH;
                state_next  = P_CR;
            end
            P_CR:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = ksrs_pkg::DIV_MUL;
                state_next  = P_CW;
            end
            P_CW:
            begin
                if (sts.div_done)
                begin
                    if (!sts.fp_match)
                    begin
                        code_next  = ksrs_pkg::ST_COLL;
                        state_next = P_OUT;
                    end
                    else
                    begin
                        cmd.pt_ld = 1'b1;
                        if (sts.axis)
                        begin
                            code_next  = ksrs_pkg::ST_ONE;
                            state_next = P_OUT;
                        end
                        else
                        begin
                            cmd.axis_set = 1'b1;
                            state_next   = P_DS;
                        end
                    end
                end
            end
            P_OUT:
            begin
                // hold until the result register is free
                if (!sts.out_busy || out_ready)
                begin
                    cmd.out_ld     = 1'b1;
                    cmd.out_status = code_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/k_sparse_recovery_sketch_top.sv
// ============================================================================
// k_sparse_recovery_sketch_top: k-sparse recovery sketch over 2-D points
// Update items fold a signed point weight into one bucket per row; probe
// items report a bucket as empty, one recovered point, or a collision.
// ============================================================================
//
//  channel | signals                                   | item
//  --------+-------------------------------------------+--------------------
//  in      | in_valid, in_ready, in_data               | update or probe
//  out     | out_valid, out_ready, out_data            | probe result
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | mask or fingerprint register write
//
//  One item at a time; the shared 4-bit-per-cycle divider sets the pace.
//  After reset a clearing pass zeroes ROWS*2*SPARSITY bucket entries, one per
//  cycle; in_ready stays low during it.
//  A waiting result does not block the next item; only a probe that finishes
//  while the output register is still full stalls until it drains.
//
module k_sparse_recovery_sketch_top #(
    parameter int ROWS     = ksrs_pkg::ROWS_DEF,
    parameter int SPARSITY = ksrs_pkg::SPARSITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ksrs_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ksrs_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data
);

    ksrs_pkg::cmd_t cmd;
    ksrs_pkg::sts_t sts;

    // config writes must land only while idle; the user is bound, the block does not enforce it, so always take them
    assign cfg_ready = 1'b1;

    // sequencer: owns all control flow
    ksrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: hashing, arithmetic, bucket memory, result register
    ksrs_dp #(
        .ROWS     (ROWS),
        .SPARSITY (SPARSITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    // no item enters while the memory is being cleared
    a_clr_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !in_ready)
        else $error("item accepted during clearing pass");

    // result load never overwrites an undelivered result
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    // divider is never restarted mid-pass
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_go |-> !sts.div_busy)
        else $error("divider started while busy");

    // a memory write comes in the cycle after its row read
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> $past(cmd.rd_row))
        else $error("bucket write without preceding read");
`endif

endmodule
